// ----- rtl/core/positional_list_engine_assert.svh -----
// assertion macros for the positional list engine
// expects aclk and aresetn in the scope of the including module
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// property checked at every clock outside reset
`define PLE_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// antecedent now, consequent at the next clock
`define PLE_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ple_pkg.sv -----
// shared types and constants of the positional list engine
// no dependencies
package ple_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 16;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 16;
    localparam int IDX_W   = 6;
    localparam int REM_W   = 6;
    localparam int ENT_W   = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_HEAD = 3'd0,
        FN_INS_TAIL = 3'd1,
        FN_RM_HEAD  = 3'd2,
        FN_RM_TAIL  = 3'd3,
        FN_INS_POS  = 3'd4,
        FN_RM_POS   = 3'd5,
        FN_AVG      = 3'd6,
        FN_MAX      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   max_value;
        logic [IDX_W-1:0]   max_index;
        logic [VAL_W-1:0]   avg_quotient;
        logic [REM_W-1:0]   avg_remainder;
        logic [ENT_W-1:0]   entries;
        logic               is_empty;
        logic [VAL_W-1:0]   front_value;
        logic [VAL_W-1:0]   back_value;
    } result_t;

endpackage

// ----- rtl/core/positional_list_engine.sv -----
// top level of the positional list engine: sequencer, value ram, divider, output register
// depends on ple_pkg, ple_ctrl, ple_ram and ple_div

// Bounded ordered list of up to DEPTH values kept in list order in a single-port-read
// ram; one item is worked on at a time and its result waits in an output register, so
// the next item is taken while the result is still pending. Every memory read goes
// through the one ram read port, one entry per clock, and that sets the time per item:
// inserts and removes shift the entries behind the position and refresh the front and
// back values, maximum and average read every entry, average then runs the bit-serial
// divider, and rejected items go straight to the result, each then held until the
// result side takes it. The ram needs no clearing after reset; only entries below the
// fill count are read.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // position [6:0], value [22:7]
    input  logic [2:0]  s_tuser,  // func [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata   // status, max_value, max_index, avg_quotient,
                                  // avg_remainder, entries, is_empty, front_value, back_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = VALUE_BITS + CW;

    result_t               res;
    logic                  res_valid, res_ready;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
    logic                  div_start, div_done;
    logic [SW-1:0]         div_num, div_quo;
    logic [CW-1:0]         div_den, div_rem;

    ple_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (func_t'(s_tuser)),
        .in_position (s_tdata[6:0]),
        .in_value    (s_tdata[22:7]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .div_start   (div_start),
        .div_num     (div_num),
        .div_den     (div_den),
        .div_done    (div_done),
        .div_quo     (div_quo),
        .div_rem     (div_rem)
    );

    ple_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ple_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_tdata_reg <= {2'b00, res.back_value, res.front_value, res.is_empty,
                            res.entries, res.avg_remainder, res.avg_quotient,
                            res.max_index, res.max_value, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/ple_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ple_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/ple_div.sv -----
// restoring divider, one quotient bit per clock
// no dependencies
module ple_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int SCW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [SCW-1:0]   step_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= SCW'(NUM_W);
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                quo_reg  <= {quo_reg[NUM_W-2:0], ge};
                rem_reg  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                step_reg <= step_reg - SCW'(1);
                if (step_reg == SCW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/ple_ctrl.sv -----
// list sequencer: decodes an item, shifts, scans and refreshes through the ram
// depends on ple_pkg and the assertion macro header
`include "positional_list_engine_assert.svh"

module ple_ctrl
    import ple_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int SW        = VALUE_BITS + CW
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  func_t                 in_func,
    input  logic [POS_W-1:0]      in_position,
    input  logic [VAL_W-1:0]      in_value,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [VALUE_BITS-1:0] ram_wdata,
    output logic                  ram_re,
    output logic [AW-1:0]         ram_raddr,
    input  logic [VALUE_BITS-1:0] ram_rdata,
    output logic                  div_start,
    output logic [SW-1:0]         div_num,
    output logic [CW-1:0]         div_den,
    input  logic                  div_done,
    input  logic [SW-1:0]         div_quo,
    input  logic [CW-1:0]         div_rem
);

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SHIFT, S_PUT, S_REF0, S_REF1, S_REF2, S_SCAN, S_DIVIDE, S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic                  shift_up_reg, shift_up_next;
    func_t                 op_reg, op_next;
    status_t               status_reg, status_next;
    logic [AW-1:0]         at_reg, at_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] front_reg, front_next;
    logic [VALUE_BITS-1:0] back_reg, back_next;
    logic [VALUE_BITS-1:0] maxv_reg, maxv_next;
    logic [AW-1:0]         maxi_reg, maxi_next;
    logic [SW-1:0]         sum_reg, sum_next;
    logic [SW-1:0]         quo_reg, quo_next;
    logic [CW-1:0]         rem_reg, rem_next;

    logic [VALUE_BITS+VAL_W-1:0] val_in_ext;
    logic [VALUE_BITS-1:0]       val_in;
    logic [CMPW-1:0]             cnt_ext, pos_ext, ins_at, rm_at, moves;
    logic [CW-1:0]               count_m1;
    logic                        empty, full;

    assign val_in_ext = {{VALUE_BITS{1'b0}}, in_value};
    assign val_in     = val_in_ext[VALUE_BITS-1:0];
    assign cnt_ext    = CMPW'(count_reg);
    assign pos_ext    = CMPW'(in_position);
    assign count_m1   = count_reg - CW'(1);
    assign empty      = count_reg == '0;
    assign full       = count_reg == CW'(DEPTH);

    always_comb begin
        unique case (in_func)
            FN_INS_HEAD: ins_at = '0;
            FN_INS_TAIL: ins_at = cnt_ext;
            default:     ins_at = empty ? '0 : pos_ext;
        endcase
        unique case (in_func)
            FN_RM_HEAD: rm_at = '0;
            FN_RM_TAIL: rm_at = cnt_ext - CMPW'(1);
            default:    rm_at = pos_ext;
        endcase
    end

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign div_num   = sum_reg;
    assign div_den   = count_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        shift_up_next  = shift_up_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        at_next        = at_reg;
        val_next       = val_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        maxv_next      = maxv_reg;
        maxi_next      = maxi_reg;
        sum_next       = sum_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        moves          = '0;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_ptr_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_func;
                    status_next = ST_OK;
                    val_next    = val_in;
                    pend_next   = 1'b0;
                    unique case (in_func) inside
                        FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
                            moves = cnt_ext - ins_at;
                            if (in_func == FN_INS_POS && !empty && pos_ext > cnt_ext) begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end else if (full) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                at_next       = AW'(ins_at);
                                cnt_next      = CW'(moves);
                                count_next    = count_reg + CW'(1);
                                shift_up_next = 1'b0;
                                rd_ptr_next   = AW'(count_m1);
                                state_next    = (moves == '0) ? S_PUT : S_SHIFT;
                            end
                        end
                        FN_RM_HEAD, FN_RM_TAIL, FN_RM_POS: begin
                            moves = cnt_ext - CMPW'(1) - rm_at;
                            if (empty) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else if (in_func == FN_RM_POS && pos_ext >= cnt_ext) begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end else begin
                                cnt_next      = CW'(moves);
                                count_next    = count_m1;
                                shift_up_next = 1'b1;
                                rd_ptr_next   = AW'(rm_at + CMPW'(1));
                                state_next    = (moves == '0) ? S_REF0 : S_SHIFT;
                            end
                        end
                        FN_AVG, FN_MAX: begin
                            if (empty) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                cnt_next    = count_reg;
                                rd_ptr_next = '0;
                                sum_next    = '0;
                                state_next  = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (cnt_reg != '0) begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = shift_up_reg ? rd_ptr_reg - AW'(1) : rd_ptr_reg + AW'(1);
                    rd_ptr_next    = shift_up_reg ? rd_ptr_reg + AW'(1) : rd_ptr_reg - AW'(1);
                    cnt_next       = cnt_reg - CW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = shift_up_reg ? S_REF0 : S_PUT;
                    end
                end
            end
            S_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = at_reg;
                ram_wdata  = val_reg;
                state_next = S_REF0;
            end
            S_REF0: begin
                if (count_reg == '0) begin
                    front_next = '0;
                    back_next  = '0;
                    state_next = S_DONE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = S_REF1;
                end
            end
            S_REF1: begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(count_m1);
                front_next = ram_rdata;
                state_next = S_REF2;
            end
            S_REF2: begin
                back_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (pend_reg) begin
                    sum_next = sum_reg + SW'(ram_rdata);
                    if (pend_addr_reg == '0 || ram_rdata > maxv_reg) begin
                        maxv_next = ram_rdata;
                        maxi_next = pend_addr_reg;
                    end
                end
                if (cnt_reg != '0) begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    rd_ptr_next    = rd_ptr_reg + AW'(1);
                    cnt_next       = cnt_reg - CW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (op_reg == FN_AVG) begin
                            div_start  = 1'b1;
                            state_next = S_DIVIDE;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DIVIDE: begin
                if (div_done) begin
                    quo_next   = div_quo;
                    rem_next   = div_rem;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            shift_up_reg <= 1'b0;
            front_reg    <= '0;
            back_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            shift_up_reg <= shift_up_next;
            front_reg    <= front_next;
            back_reg     <= back_next;
        end
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        status_reg    <= status_next;
        at_reg        <= at_next;
        val_reg       <= val_next;
        maxv_reg      <= maxv_next;
        maxi_reg      <= maxi_next;
        sum_reg       <= sum_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
    end

    // result fields widened then cut to port widths
    logic [VALUE_BITS+VAL_W-1:0] maxv_ext, front_ext, back_ext;
    logic [AW+IDX_W-1:0]         maxi_ext;
    logic [SW+VAL_W-1:0]         quo_ext;
    logic [CW+REM_W-1:0]         rem_ext;
    logic [CW+ENT_W-1:0]         count_ext;
    logic                        ok_max, ok_avg;

    assign maxv_ext  = {{VAL_W{1'b0}}, maxv_reg};
    assign front_ext = {{VAL_W{1'b0}}, front_reg};
    assign back_ext  = {{VAL_W{1'b0}}, back_reg};
    assign maxi_ext  = {{IDX_W{1'b0}}, maxi_reg};
    assign quo_ext   = {{VAL_W{1'b0}}, quo_reg};
    assign rem_ext   = {{REM_W{1'b0}}, rem_reg};
    assign count_ext = {{ENT_W{1'b0}}, count_reg};
    assign ok_max    = status_reg == ST_OK && op_reg == FN_MAX;
    assign ok_avg    = status_reg == ST_OK && op_reg == FN_AVG;

    always_comb begin
        res.status        = status_reg;
        res.max_value     = ok_max ? maxv_ext[VAL_W-1:0] : '0;
        res.max_index     = ok_max ? maxi_ext[IDX_W-1:0] : '0;
        res.avg_quotient  = ok_avg ? quo_ext[VAL_W-1:0] : '0;
        res.avg_remainder = ok_avg ? rem_ext[REM_W-1:0] : '0;
        res.entries       = count_ext[ENT_W-1:0];
        res.is_empty      = empty;
        res.front_value   = empty ? '0 : front_ext[VAL_W-1:0];
        res.back_value    = empty ? '0 : back_ext[VAL_W-1:0];
    end

    `PLE_CHECK(a_count_bound, count_reg <= CW'(DEPTH), "fill count above depth")
    `PLE_CHECK(a_ram_no_collide, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "ram read and write hit one entry")
    `PLE_CHECK(a_div_in_divide, div_done |-> (state_reg == S_DIVIDE), "divider finished outside divide")
    `PLE_CHECK_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != S_IDLE, "item accepted but sequencer idle")

endmodule
